### design/quat_scale_to_world_matrix_assert.svh
// assertion macros used by the quaternion transform rtl
`ifndef QUAT_SCALE_TO_WORLD_MATRIX_ASSERT_SVH
`define QUAT_SCALE_TO_WORLD_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, switched off while reset is high
`define QSTW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property that also holds through reset
`define QSTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSTW_ASSERT(lbl, clk, rst, prop, msg)
`define QSTW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/qstw_pkg.sv
// shared types and constants of the quaternion transform pipeline
package qstw_pkg;

   // field widths
   localparam int Q_W      = 16;
   localparam int SCALE_W  = 16;
   localparam int POS_W    = 32;
   localparam int M_W      = 24;

   // doubled product 2ab >> 14 equals ab >> 13
   localparam int DP_SHIFT = 13;
   localparam int PROD_W   = 2 * Q_W - DP_SHIFT;
   // matrix entry before scaling, with headroom for the sums
   localparam int ENT_W    = PROD_W + 1;
   // entry times scale, scale zero-extended to signed
   localparam int MUL_W    = ENT_W + SCALE_W + 1;
   localparam int SCALE_SHR = 8;
   localparam int SHR_W    = MUL_W - SCALE_SHR;

   localparam int ONE_Q14  = 16384;
   localparam int NUM_ENT  = 9;

   // stages from accepted word to result strobe
   localparam int PIPE_DEPTH = 4;

   // matrix entry positions
   localparam int M00 = 0;
   localparam int M01 = 1;
   localparam int M02 = 2;
   localparam int M10 = 3;
   localparam int M11 = 4;
   localparam int M12 = 5;
   localparam int M20 = 6;
   localparam int M21 = 7;
   localparam int M22 = 8;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_Z = 2'd2;

   typedef struct packed {
      logic signed [Q_W-1:0]   quat_x;
      logic signed [Q_W-1:0]   quat_y;
      logic signed [Q_W-1:0]   quat_z;
      logic signed [Q_W-1:0]   quat_w;
      logic [SCALE_W-1:0]      uniform_scale;
      logic signed [POS_W-1:0] origin_x;
      logic signed [POS_W-1:0] origin_y;
      logic signed [POS_W-1:0] origin_z;
   } req_type;

   typedef struct packed {
      logic signed [M_W-1:0]   m00;
      logic signed [M_W-1:0]   m01;
      logic signed [M_W-1:0]   m02;
      logic signed [M_W-1:0]   m10;
      logic signed [M_W-1:0]   m11;
      logic signed [M_W-1:0]   m12;
      logic signed [M_W-1:0]   m20;
      logic signed [M_W-1:0]   m21;
      logic signed [M_W-1:0]   m22;
      logic signed [POS_W-1:0] trans_x;
      logic signed [POS_W-1:0] trans_y;
      logic signed [POS_W-1:0] trans_z;
   } rsp_type;

   // the nine doubled quaternion products
   typedef struct packed {
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] xy;
      logic signed [PROD_W-1:0] xz;
      logic signed [PROD_W-1:0] xw;
      logic signed [PROD_W-1:0] yy;
      logic signed [PROD_W-1:0] yz;
      logic signed [PROD_W-1:0] yw;
      logic signed [PROD_W-1:0] zw;
      logic signed [PROD_W-1:0] zz;
   } prod_type;

   typedef logic signed [ENT_W-1:0] ent_type;
   typedef logic signed [M_W-1:0]   m_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } vec3_type;

endpackage

### design/qstw_prod.sv
// stage one: the nine doubled quaternion products
module qstw_prod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_i,
   input  qstw_pkg::req_type            req_i,
   output logic                         valid_o,
   output qstw_pkg::prod_type           prod_o,
   output logic [qstw_pkg::SCALE_W-1:0] scale_o
);
   import qstw_pkg::*;

   logic               valid_ff;
   prod_type           prod_in;
   prod_type           prod_ff;
   logic [SCALE_W-1:0] scale_ff;

   // floor(2ab / 2^14), taken straight from the full product
   function automatic logic signed [PROD_W-1:0] dprod(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
      logic signed [2*Q_W-1:0] p;
      p = a * b;
      return p[2*Q_W-1 -: PROD_W];
   endfunction

   // product array
   always_comb begin
      prod_in.xx = dprod(req_i.quat_x, req_i.quat_x);
      prod_in.xy = dprod(req_i.quat_x, req_i.quat_y);
      prod_in.xz = dprod(req_i.quat_x, req_i.quat_z);
      prod_in.xw = dprod(req_i.quat_x, req_i.quat_w);
      prod_in.yy = dprod(req_i.quat_y, req_i.quat_y);
      prod_in.yz = dprod(req_i.quat_y, req_i.quat_z);
      prod_in.yw = dprod(req_i.quat_y, req_i.quat_w);
      prod_in.zw = dprod(req_i.quat_z, req_i.quat_w);
      prod_in.zz = dprod(req_i.quat_z, req_i.quat_z);
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      scale_ff <= req_i.uniform_scale;
   end

   assign valid_o = valid_ff;
   assign prod_o  = prod_ff;
   assign scale_o = scale_ff;

endmodule

### design/qstw_comb.sv
// stage two: unscaled matrix entries from the doubled products
module qstw_comb (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_i,
   input  qstw_pkg::prod_type           prod_i,
   input  logic [qstw_pkg::SCALE_W-1:0] scale_i,
   output logic                         valid_o,
   output qstw_pkg::ent_type            ent_o [qstw_pkg::NUM_ENT],
   output logic [qstw_pkg::SCALE_W-1:0] scale_o
);
   import qstw_pkg::*;

   logic               valid_ff;
   ent_type            ent_in [NUM_ENT];
   ent_type            ent_ff [NUM_ENT];
   logic [SCALE_W-1:0] scale_ff;
   ent_type            one;

   assign one = ENT_W'(ONE_Q14);

   // diagonal and off-diagonal sums
   always_comb begin
      ent_in[M00] = one - (ENT_W'(prod_i.yy) + ENT_W'(prod_i.zz));
      ent_in[M01] = ENT_W'(prod_i.xy) + ENT_W'(prod_i.zw);
      ent_in[M02] = ENT_W'(prod_i.xz) - ENT_W'(prod_i.yw);
      ent_in[M10] = ENT_W'(prod_i.xy) - ENT_W'(prod_i.zw);
      ent_in[M11] = one - (ENT_W'(prod_i.xx) + ENT_W'(prod_i.zz));
      ent_in[M12] = ENT_W'(prod_i.yz) + ENT_W'(prod_i.xw);
      ent_in[M20] = ENT_W'(prod_i.xz) + ENT_W'(prod_i.yw);
      ent_in[M21] = ENT_W'(prod_i.yz) - ENT_W'(prod_i.xw);
      ent_in[M22] = one - (ENT_W'(prod_i.xx) + ENT_W'(prod_i.yy));
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      scale_ff <= scale_i;
   end

   assign valid_o = valid_ff;
   assign ent_o   = ent_ff;
   assign scale_o = scale_ff;

endmodule

### design/qstw_scale.sv
// stages three and four: scale multiply, shift and saturate to q10.14
module qstw_scale (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_i,
   input  qstw_pkg::ent_type            ent_i [qstw_pkg::NUM_ENT],
   input  logic [qstw_pkg::SCALE_W-1:0] scale_i,
   output logic                         valid_o,
   output qstw_pkg::m_type              m_o [qstw_pkg::NUM_ENT]
);
   import qstw_pkg::*;

   logic                     mul_valid_ff;
   logic                     out_valid_ff;
   logic signed [MUL_W-1:0]  mul_in [NUM_ENT];
   logic signed [MUL_W-1:0]  mul_ff [NUM_ENT];
   m_type                    m_in [NUM_ENT];
   m_type                    m_ff [NUM_ENT];
   logic signed [SCALE_W:0]  scale_s;

   // floor shift by eight, then clamp to the 24 bit range
   function automatic m_type sat_shift(input logic signed [MUL_W-1:0] v);
      logic [SHR_W-1:0]      s;
      logic [SHR_W-M_W:0]    top;
      m_type                 r;
      s   = v[MUL_W-1:SCALE_SHR];
      top = s[SHR_W-1:M_W-1];
      if ((&top) || !(|top)) begin
         r = s[M_W-1:0];
      end else if (s[SHR_W-1]) begin
         r = {1'b1, {(M_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(M_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign scale_s = $signed({1'b0, scale_i});

   // one multiplier per entry
   always_comb begin
      for (int i = 0; i < NUM_ENT; i++) begin
         mul_in[i] = ent_i[i] * scale_s;
      end
   end

   // shift and clamp
   always_comb begin
      for (int i = 0; i < NUM_ENT; i++) begin
         m_in[i] = sat_shift(mul_ff[i]);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= valid_i;
         out_valid_ff <= mul_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      m_ff   <= m_in;
   end

   assign valid_o = out_valid_ff;
   assign m_o     = m_ff;

endmodule

### design/qstw_trans.sv
// eye offset registers and the saturating translation path
module qstw_trans (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [qstw_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [qstw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  qstw_pkg::vec3_type              origin_i,
   output qstw_pkg::vec3_type              trans_o
);
   import qstw_pkg::*;

   logic signed [POS_W-1:0] eye_x_ff;
   logic signed [POS_W-1:0] eye_y_ff;
   logic signed [POS_W-1:0] eye_z_ff;
   vec3_type                diff_in;
   vec3_type                stg_ff [PIPE_DEPTH];

   // origin minus eye, clamped to 32 bits
   function automatic logic signed [POS_W-1:0] sat_sub(input logic signed [POS_W-1:0] a,
                                                       input logic signed [POS_W-1:0] b);
      logic signed [POS_W:0]   d;
      logic signed [POS_W-1:0] r;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      if (d[POS_W] == d[POS_W-1]) begin
         r = d[POS_W-1:0];
      end else if (d[POS_W]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff <= '0;
         eye_y_ff <= '0;
         eye_z_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_EYE_X: begin
               eye_x_ff <= POS_W'(csr_wdata);
            end
            CSR_EYE_Y: begin
               eye_y_ff <= POS_W'(csr_wdata);
            end
            CSR_EYE_Z: begin
               eye_z_ff <= POS_W'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      diff_in.x = sat_sub(origin_i.x, eye_x_ff);
      diff_in.y = sat_sub(origin_i.y, eye_y_ff);
      diff_in.z = sat_sub(origin_i.z, eye_z_ff);
   end

   // delay line matching the matrix pipeline
   always_ff @(posedge clock) begin
      stg_ff[0] <= diff_in;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         stg_ff[k] <= stg_ff[k-1];
      end
   end

   assign trans_o = stg_ff[PIPE_DEPTH-1];

endmodule

### design/quat_scale_to_world_matrix.sv
// Quaternion plus uniform scale to a 3x3 world matrix and translation. A word is
// taken on every clock at which start is high; busy never rises, so one word per
// cycle is sustained. The result shows on rsp_data for exactly one cycle with
// rsp_valid high after the word was taken and passed through products, entry
// sums, scale multiply, then shift and saturate, one register stage each. The
// receiver cannot hold results off and none is held back. Eye offsets x, y, z
// are written through csr_we/csr_idx/csr_wdata at indexes 0, 1, 2; other
// indexes are ignored. Write them only while no word is in flight.
`include "quat_scale_to_world_matrix_assert.svh"
module quat_scale_to_world_matrix (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  qstw_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output qstw_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [qstw_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [qstw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import qstw_pkg::*;

   logic               accept;
   logic               p_valid;
   prod_type           p_prod;
   logic [SCALE_W-1:0] p_scale;
   logic               c_valid;
   ent_type            c_ent [NUM_ENT];
   logic [SCALE_W-1:0] c_scale;
   logic               s_valid;
   m_type              s_m [NUM_ENT];
   vec3_type           origin;
   vec3_type           trans;

   // fully pipelined, never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   qstw_prod u_prod (
      .clock   (clock),
      .reset   (reset),
      .valid_i (accept),
      .req_i   (req_data),
      .valid_o (p_valid),
      .prod_o  (p_prod),
      .scale_o (p_scale)
   );

   qstw_comb u_comb (
      .clock   (clock),
      .reset   (reset),
      .valid_i (p_valid),
      .prod_i  (p_prod),
      .scale_i (p_scale),
      .valid_o (c_valid),
      .ent_o   (c_ent),
      .scale_o (c_scale)
   );

   qstw_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .valid_i (c_valid),
      .ent_i   (c_ent),
      .scale_i (c_scale),
      .valid_o (s_valid),
      .m_o     (s_m)
   );

   // translation side
   assign origin.x = req_data.origin_x;
   assign origin.y = req_data.origin_y;
   assign origin.z = req_data.origin_z;

   qstw_trans u_trans (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .origin_i  (origin),
      .trans_o   (trans)
   );

   // result word
   assign rsp_valid        = s_valid;
   assign rsp_data.m00     = s_m[M00];
   assign rsp_data.m01     = s_m[M01];
   assign rsp_data.m02     = s_m[M02];
   assign rsp_data.m10     = s_m[M10];
   assign rsp_data.m11     = s_m[M11];
   assign rsp_data.m12     = s_m[M12];
   assign rsp_data.m20     = s_m[M20];
   assign rsp_data.m21     = s_m[M21];
   assign rsp_data.m22     = s_m[M22];
   assign rsp_data.trans_x = trans.x;
   assign rsp_data.trans_y = trans.y;
   assign rsp_data.trans_z = trans.z;

   // checks
   `QSTW_ASSERT(a_word_out, clock, reset, accept |-> ##PIPE_DEPTH rsp_valid, "word lost in pipeline")
   `QSTW_ASSERT(a_no_extra, clock, reset, rsp_valid |-> $past(accept, PIPE_DEPTH), "result without word")
   `QSTW_ASSERT(a_zero_scale, clock, reset, (rsp_valid && $past(req_data.uniform_scale, PIPE_DEPTH) == '0) |-> (rsp_data.m00 == '0 && rsp_data.m11 == '0 && rsp_data.m22 == '0), "zero scale gave nonzero diagonal")
   `QSTW_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result strobe after reset")

endmodule

### test/quat_scale_to_world_matrix_tb.sv
// self-checking testbench of the quaternion, scale and origin to world matrix block
module quat_scale_to_world_matrix_tb;
   import qstw_pkg::*;

   // register index that the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PRINT_LIMIT = 40;
   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -64'sd2147483648;
   localparam longint M_MAX   = 64'sd8388607;
   localparam longint M_MIN   = -64'sd8388608;

   // scoreboard: own copy of the eye offsets, the predictor and the matrices still due
   class matrix_checker;
      longint  eye_off[3];
      rsp_type matrices_due[$];
      int      mismatches;
      int      words_in;
      int      matrices_out;

      function new();
         eye_off = '{0, 0, 0};
         mismatches = 0;
         words_in = 0;
         matrices_out = 0;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("mismatch %0d: %s", mismatches, msg);
      endtask

      function void set_eye(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_EYE_X: eye_off[0] = longint'($signed(val));
            CSR_EYE_Y: eye_off[1] = longint'($signed(val));
            CSR_EYE_Z: eye_off[2] = longint'($signed(val));
            default: ;
         endcase
      endfunction

      // doubled product 2ab in q.14, floor shift
      function longint dbl_prod(longint a, longint b);
         return (2 * a * b) >>> 14;
      endfunction

      // q.14 entry times q8.8 scale, floor shift, clamp to 24 bits
      function m_type scale_entry(longint e, longint s);
         longint v;
         v = (e * s) >>> 8;
         if (v > M_MAX) v = M_MAX;
         if (v < M_MIN) v = M_MIN;
         return m_type'(v);
      endfunction

      // origin minus eye offset, clamped to 32 bits
      function logic [POS_W-1:0] offset_axis(logic signed [POS_W-1:0] org, longint eye);
         longint d;
         d = longint'(org) - eye;
         if (d > POS_MAX) d = POS_MAX;
         if (d < POS_MIN) d = POS_MIN;
         return d[POS_W-1:0];
      endfunction

      function rsp_type world_matrix_of(req_type w);
         longint x, y, z, q, s;
         longint xx, xy, xz, xw, yy, yz, yw, zw, zz;
         rsp_type r;
         x = longint'(w.quat_x);
         y = longint'(w.quat_y);
         z = longint'(w.quat_z);
         q = longint'(w.quat_w);
         s = longint'(w.uniform_scale);
         xx = dbl_prod(x, x); xy = dbl_prod(x, y); xz = dbl_prod(x, z);
         xw = dbl_prod(x, q); yy = dbl_prod(y, y); yz = dbl_prod(y, z);
         yw = dbl_prod(y, q); zw = dbl_prod(z, q); zz = dbl_prod(z, z);
         r.m00 = scale_entry(ONE_Q14 - (yy + zz), s);
         r.m01 = scale_entry(xy + zw, s);
         r.m02 = scale_entry(xz - yw, s);
         r.m10 = scale_entry(xy - zw, s);
         r.m11 = scale_entry(ONE_Q14 - (xx + zz), s);
         r.m12 = scale_entry(yz + xw, s);
         r.m20 = scale_entry(xz + yw, s);
         r.m21 = scale_entry(yz - xw, s);
         r.m22 = scale_entry(ONE_Q14 - (xx + yy), s);
         r.trans_x = offset_axis(w.origin_x, eye_off[0]);
         r.trans_y = offset_axis(w.origin_y, eye_off[1]);
         r.trans_z = offset_axis(w.origin_z, eye_off[2]);
         return r;
      endfunction

      function void note_word(req_type w);
         words_in++;
         matrices_due.push_back(world_matrix_of(w));
      endfunction

      function int pending();
         return matrices_due.size();
      endfunction

      task compare_field(string name, longint got, longint want);
         if (got != want)
            report($sformatf("matrix %0d field %s got %0d want %0d",
                             matrices_out, name, got, want));
      endtask

      task check_matrix(rsp_type got);
         rsp_type want;
         if (matrices_due.size() == 0) begin
            report("result strobe with no word outstanding");
            return;
         end
         want = matrices_due.pop_front();
         compare_field("m00", got.m00, want.m00);
         compare_field("m01", got.m01, want.m01);
         compare_field("m02", got.m02, want.m02);
         compare_field("m10", got.m10, want.m10);
         compare_field("m11", got.m11, want.m11);
         compare_field("m12", got.m12, want.m12);
         compare_field("m20", got.m20, want.m20);
         compare_field("m21", got.m21, want.m21);
         compare_field("m22", got.m22, want.m22);
         compare_field("trans_x", got.trans_x, want.trans_x);
         compare_field("trans_y", got.trans_y, want.trans_y);
         compare_field("trans_z", got.trans_z, want.trans_z);
         matrices_out++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   matrix_checker board;
   int idle_cycles;
   int eye_settings;

   quat_scale_to_world_matrix dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // clock, period 2
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // sample both channels at the rising edge, watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            board.check_matrix(rsp_data);
         if (start && !busy)
            board.note_word(req_data);
         if (rsp_valid || (start && !busy))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("FAIL quat_scale_to_world_matrix");
            $finish;
         end
      end
   end

   function automatic req_type make_word(int qx, int qy, int qz, int qw, int s,
                                         longint ox, longint oy, longint oz);
      req_type w;
      w.quat_x = qx[Q_W-1:0];
      w.quat_y = qy[Q_W-1:0];
      w.quat_z = qz[Q_W-1:0];
      w.quat_w = qw[Q_W-1:0];
      w.uniform_scale = s[SCALE_W-1:0];
      w.origin_x = ox[POS_W-1:0];
      w.origin_y = oy[POS_W-1:0];
      w.origin_z = oz[POS_W-1:0];
      return w;
   endfunction

   // quaternion component: mostly in range, some full width, some extremes
   function automatic int pick_comp();
      int r;
      int extremes[5] = '{-32768, 32767, -16384, 16384, 0};
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 32768) - 16384;
      if (r < 8) return $urandom_range(0, 65535) - 32768;
      return extremes[$urandom_range(0, 4)];
   endfunction

   function automatic int pick_scale();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 65535;
      if (r == 2) return 256;
      return $urandom_range(0, 65535);
   endfunction

   function automatic longint pick_pos();
      longint extremes[4] = '{POS_MIN, POS_MAX, 0, -1};
      if ($urandom_range(0, 4) == 0) return extremes[$urandom_range(0, 3)];
      return longint'($signed($urandom()));
   endfunction

   function automatic req_type random_word();
      return make_word(pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_scale(),
                       pick_pos(), pick_pos(), pick_pos());
   endfunction

   // gap after a word: mostly none, some short, a few long
   function automatic int pick_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one word, hold it until taken, then, for a nonzero gap, idle with junk on the data
   task send_word(req_type w, int gap);
      @(negedge clock);
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_data <= random_word();
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop sending and let every outstanding matrix come back
   task drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, longint val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      board.set_eye(idx, val[CSR_DATA_W-1:0]);
   endtask

   // new eye offsets, with a write to the spare index that must change nothing
   task program_eyes(longint ex, longint ey, longint ez);
      write_reg(CSR_EYE_X, ex);
      write_reg(CSR_SPARE, longint'($signed($urandom())));
      write_reg(CSR_EYE_Y, ey);
      write_reg(CSR_EYE_Z, ez);
      @(negedge clock);
      csr_we <= 1'b0;
      eye_settings++;
   endtask

   // random words, first half possibly back to back, optional drain midway
   task run_random(int count, bit burst_first, bit drain_mid);
      for (int i = 0; i < count; i++) begin
         if (drain_mid && i == count / 2)
            drain();
         send_word(random_word(), pick_gap(burst_first && i < count / 2));
      end
   endtask

   initial begin
      board = new();
      idle_cycles = 0;
      eye_settings = 1;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // eye offsets at reset value: matrix corner cases
      send_word(make_word(0, 0, 0, 16384, 256, 0, 0, 0), 0);
      send_word(make_word(0, 0, 0, 16384, 0, 1, -1, 256), 1);
      send_word(make_word(0, 0, 0, 16384, 65535, POS_MAX, POS_MIN, 0), 0);
      send_word(make_word(16384, 0, 0, 0, 256, 0, 0, 0), 0);
      send_word(make_word(0, 16384, 0, 0, 256, 0, 0, 0), 2);
      send_word(make_word(0, 0, 16384, 0, 256, 0, 0, 0), 0);
      send_word(make_word(0, 0, 0, -16384, 512, 0, 0, 0), 0);
      send_word(make_word(11585, 0, 0, 11585, 256, 0, 0, 0), 0);
      send_word(make_word(-8192, 8192, -8192, 8192, 300, 0, 0, 0), 0);
      // zero quaternion, not normalised
      send_word(make_word(0, 0, 0, 0, 256, 0, 0, 0), 0);
      // out of range components drive the entries into saturation
      send_word(make_word(-32768, -32768, -32768, -32768, 65535, 0, 0, 0), 0);
      send_word(make_word(32767, 32767, 32767, 32767, 65535, 0, 0, 0), 0);
      send_word(make_word(32767, -32768, 32767, -32768, 65535, 0, 0, 0), 3);
      send_word(make_word(-32768, 32767, -32768, 32767, 1, -1, -1, -1), 0);
      run_random(150, 1'b1, 1'b0);

      // extreme eye offsets: translation saturates both ways
      drain();
      program_eyes(POS_MAX, POS_MIN, 0);
      send_word(make_word(0, 0, 0, 16384, 256, POS_MIN, POS_MAX, POS_MIN), 0);
      send_word(make_word(0, 0, 0, 16384, 256, POS_MAX, POS_MIN, POS_MAX), 0);
      send_word(make_word(0, 0, 0, 16384, 256, 0, 0, 0), 1);
      send_word(make_word(0, 0, 0, 16384, 256, -1, -1, -1), 0);
      send_word(make_word(0, 0, 0, 16384, 256, POS_MIN + 1, -2, 1), 0);
      run_random(150, 1'b0, 1'b0);

      drain();
      program_eyes(POS_MIN, POS_MAX, -1);
      run_random(150, 1'b1, 1'b0);

      drain();
      program_eyes(longint'($signed($urandom())), longint'($signed($urandom())),
                   longint'($signed($urandom())));
      run_random(150, 1'b0, 1'b0);

      drain();
      program_eyes(longint'($signed($urandom())), 0, longint'($signed($urandom())));
      run_random(150, 1'b0, 1'b1);

      // let the pipeline empty, then keep watching for stray strobes
      @(negedge clock);
      start <= 1'b0;
      for (int n = 0; n < 1000 && board.pending() != 0; n++)
         @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (board.pending() != 0)
         board.report($sformatf("%0d matrices never arrived", board.pending()));

      $display("covered %0d words over %0d eye offset settings, extremes and spare index included",
               board.words_in, eye_settings);
      $display("checked %0d matrices, %0d mismatches", board.matrices_out, board.mismatches);
      if (board.mismatches == 0)
         $display("PASS quat_scale_to_world_matrix");
      else
         $display("FAIL quat_scale_to_world_matrix");
      $finish;
   end

endmodule
